// ----- hw/rtl/obis_meter_line_parser_macros.svh -----
// assertion macros for the obis meter line parser checker
// needs a clock and a reset signal in the scope where a macro is used
`ifndef OBIS_METER_LINE_PARSER_MACROS_SVH
`define OBIS_METER_LINE_PARSER_MACROS_SVH

// same-cycle implication, off during reset
`define OBIS_ASSERT_IMPLY(name, lhs, rhs, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, off during reset
`define OBIS_ASSERT_NEXT(name, lhs, rhs, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ----- hw/rtl/obis_pkg.sv -----
// shared types, character codes and the obis code table of the line parser
// no dependencies
package obis_pkg;

   localparam int CODE_CHARS  = 16;
   localparam int FRAC_DIGITS = 3;
   localparam int VALUE_BITS  = 40;

   localparam int NUM_CODES    = 26;
   localparam int CODE_MAX_LEN = 10;
   localparam int STAMP_LEN    = 9;
   localparam int IDX_BITS     = 5;
   localparam int LEN_BITS     = $clog2(CODE_CHARS + 1);
   localparam int FC_BITS      = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
   localparam int SCALE_BITS   = 20;

   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [2:0] {
      PH_CODE,
      PH_LEAD,
      PH_SIGN,
      PH_INT,
      PH_FRAC,
      PH_DONE,
      PH_STAR
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_UNKNOWN,
      ST_NO_PAREN,
      ST_NO_STAR,
      ST_STAR_FIRST,
      ST_NO_DIGITS
   } status_type;

   // codes padded with spaces to the longest length, first char in the top byte
   localparam logic [8*CODE_MAX_LEN-1:0] CODE_TEXT [NUM_CODES] = '{
      "1-0:1.8.0 ", "1-0:2.8.0 ", "1-0:3.8.0 ", "1-0:4.8.0 ",
      "1-0:1.7.0 ", "1-0:2.7.0 ", "1-0:3.7.0 ", "1-0:4.7.0 ",
      "1-0:21.7.0", "1-0:22.7.0", "1-0:41.7.0", "1-0:42.7.0",
      "1-0:61.7.0", "1-0:62.7.0",
      "1-0:23.7.0", "1-0:24.7.0", "1-0:43.7.0", "1-0:44.7.0",
      "1-0:63.7.0", "1-0:64.7.0",
      "1-0:32.7.0", "1-0:52.7.0", "1-0:72.7.0",
      "1-0:31.7.0", "1-0:51.7.0", "1-0:71.7.0"
   };

   localparam logic [LEN_BITS-1:0] CODE_LEN [NUM_CODES] = '{
      LEN_BITS'(9), LEN_BITS'(9), LEN_BITS'(9), LEN_BITS'(9),
      LEN_BITS'(9), LEN_BITS'(9), LEN_BITS'(9), LEN_BITS'(9),
      LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10),
      LEN_BITS'(10), LEN_BITS'(10),
      LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10),
      LEN_BITS'(10), LEN_BITS'(10),
      LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10),
      LEN_BITS'(10), LEN_BITS'(10), LEN_BITS'(10)
   };

   localparam logic [8*STAMP_LEN-1:0] STAMP_TEXT = "0-0:1.0.0";

   localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                matched;
      logic [IDX_BITS-1:0] index;
      logic                dash_seen;
      logic                stamp_seen;
   } code_info_type;

   typedef struct packed {
      phase_type              phase;
      logic                   neg;
      logic                   digit;
      logic [VALUE_BITS-1:0]  acc;
      logic [FC_BITS-1:0]     frac_cnt;
   } num_info_type;

   // power of ten that brings a value with frac_cnt fraction digits to full scale
   function automatic logic [SCALE_BITS-1:0] frac_scale(input logic [FC_BITS-1:0] frac_cnt);
      logic [SCALE_BITS-1:0] s;
      s = SCALE_BITS'(1);
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (i >= int'(frac_cnt)) begin
            s = SCALE_BITS'(s * SCALE_BITS'(10));
         end
      end
      return s;
   endfunction

endpackage

// ----- hw/rtl/obis_code_match.sv -----
// code field tracking: per-code match bits, code length, dash and timestamp detection
// depends on obis_pkg
module obis_code_match (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   line_end,
   input  logic                   in_code,
   input  logic [7:0]             data_byte,
   output obis_pkg::code_info_type code_info
);
   import obis_pkg::*;

   logic [NUM_CODES-1:0]     alive_ff, alive_in;
   logic [LEN_BITS-1:0]      code_len_ff, code_len_in;
   logic [8*STAMP_LEN-1:0]   recent_ff, recent_in;
   logic                     dash_ff, dash_in;
   logic                     stamp_ff, stamp_in;
   logic [NUM_CODES-1:0]     hit;

   // true when table code k holds byte c at position pos
   function automatic logic char_fits(input int k, input logic [LEN_BITS-1:0] pos,
                                      input logic [7:0] c);
      logic r;
      r = 1'b0;
      for (int p = 0; p < CODE_MAX_LEN; p++) begin
         if (int'(pos) == p && CODE_TEXT[k][8*(CODE_MAX_LEN-p)-1 -: 8] == c) begin
            r = 1'b1;
         end
      end
      return r;
   endfunction

   always_comb begin
      alive_in    = alive_ff;
      code_len_in = code_len_ff;
      recent_in   = recent_ff;
      dash_in     = dash_ff;
      stamp_in    = stamp_ff;
      if (step) begin
         if (data_byte == CHAR_DASH) begin
            dash_in = 1'b1;
         end
         recent_in = {recent_ff[8*(STAMP_LEN-1)-1:0], data_byte};
         if (recent_in == STAMP_TEXT) begin
            stamp_in = 1'b1;
         end
         if (in_code && data_byte != CHAR_LPAREN) begin
            // a code char past the table length kills that entry
            for (int k = 0; k < NUM_CODES; k++) begin
               alive_in[k] = alive_ff[k] && (code_len_ff < CODE_LEN[k]) &&
                             char_fits(k, code_len_ff, data_byte);
            end
            if (code_len_ff < LEN_BITS'(CODE_CHARS)) begin
               code_len_in = code_len_ff + LEN_BITS'(1);
            end
         end
      end
      if (line_end) begin
         alive_in    = '1;
         code_len_in = '0;
         recent_in   = '0;
         dash_in     = 1'b0;
         stamp_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff    <= '1;
         code_len_ff <= '0;
         recent_ff   <= '0;
         dash_ff     <= 1'b0;
         stamp_ff    <= 1'b0;
      end else begin
         alive_ff    <= alive_in;
         code_len_ff <= code_len_in;
         recent_ff   <= recent_in;
         dash_ff     <= dash_in;
         stamp_ff    <= stamp_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CODES; k++) begin
         hit[k] = alive_ff[k] && (code_len_ff == CODE_LEN[k]);
      end
      code_info.matched    = |hit;
      code_info.index      = '0;
      // lowest table position wins
      for (int k = NUM_CODES - 1; k >= 0; k--) begin
         if (hit[k]) begin
            code_info.index = IDX_BITS'(k);
         end
      end
      code_info.dash_seen  = dash_ff;
      code_info.stamp_seen = stamp_ff;
   end

endmodule

// ----- hw/rtl/obis_num_parse.sv -----
// value field scanner: phase, sign, digit flag, saturating accumulator
// depends on obis_pkg
module obis_num_parse (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  line_end,
   input  logic [7:0]            data_byte,
   output obis_pkg::num_info_type num_info
);
   import obis_pkg::*;

   num_info_type num_ff, num_in;
   logic         is_digit;
   logic         is_space;
   logic [3:0]   digit_val;
   logic [VALUE_BITS-1:0] acc_next;

   // acc * 10 + d, clamped at the magnitude cap
   function automatic logic [VALUE_BITS-1:0] mul10_add(input logic [VALUE_BITS-1:0] acc,
                                                      input logic [3:0] d);
      logic [VALUE_BITS+3:0] t;
      t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_BITS+4)'(d);
      if (t > {4'b0, MAG_CAP}) begin
         return MAG_CAP;
      end
      return t[VALUE_BITS-1:0];
   endfunction

   assign is_digit  = data_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_space  = data_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF};
   assign digit_val = data_byte[3:0];
   assign acc_next  = mul10_add(num_ff.acc, digit_val);

   always_comb begin
      num_in = num_ff;
      if (step) begin
         if (num_ff.phase == PH_CODE) begin
            if (data_byte == CHAR_LPAREN) begin
               num_in.phase = PH_LEAD;
            end
         end else if (num_ff.phase != PH_STAR) begin
            if (data_byte == CHAR_STAR) begin
               num_in.phase = PH_STAR;
            end else begin
               case (num_ff.phase)
                  PH_LEAD, PH_SIGN: begin
                     if (num_ff.phase == PH_LEAD && is_space) begin
                        num_in.phase = PH_LEAD;
                     end else if (num_ff.phase == PH_LEAD &&
                                  (data_byte == CHAR_PLUS || data_byte == CHAR_DASH)) begin
                        num_in.neg   = num_ff.neg | (data_byte == CHAR_DASH);
                        num_in.phase = PH_SIGN;
                     end else if (is_digit) begin
                        num_in.digit = 1'b1;
                        num_in.acc   = acc_next;
                        num_in.phase = PH_INT;
                     end else if (data_byte == CHAR_DOT) begin
                        num_in.phase = PH_FRAC;
                     end else begin
                        num_in.phase = PH_DONE;
                     end
                  end
                  PH_INT: begin
                     if (is_digit) begin
                        num_in.acc = acc_next;
                     end else if (data_byte == CHAR_DOT) begin
                        num_in.phase = PH_FRAC;
                     end else begin
                        num_in.phase = PH_DONE;
                     end
                  end
                  PH_FRAC: begin
                     if (is_digit) begin
                        num_in.digit = 1'b1;
                        // digits past the kept precision are dropped
                        if (int'(num_ff.frac_cnt) < FRAC_DIGITS) begin
                           num_in.acc      = acc_next;
                           num_in.frac_cnt = num_ff.frac_cnt + FC_BITS'(1);
                        end
                     end else begin
                        num_in.phase = PH_DONE;
                     end
                  end
                  default: begin
                     num_in.phase = num_ff.phase;
                  end
               endcase
            end
         end
      end
      if (line_end) begin
         num_in.phase    = PH_CODE;
         num_in.neg      = 1'b0;
         num_in.digit    = 1'b0;
         num_in.acc      = '0;
         num_in.frac_cnt = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff.phase    <= PH_CODE;
         num_ff.neg      <= 1'b0;
         num_ff.digit    <= 1'b0;
         num_ff.acc      <= '0;
         num_ff.frac_cnt <= '0;
      end else begin
         num_ff <= num_in;
      end
   end

   assign num_info = num_ff;

endmodule

// ----- hw/rtl/obis_result.sv -----
// line end evaluation: status, scaling and clamping, and the result register
// depends on obis_pkg
module obis_result (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           line_end,
   input  obis_pkg::code_info_type        code_info,
   input  obis_pkg::num_info_type         num_info,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [obis_pkg::IDX_BITS-1:0]  rsp_quantity_index,
   output logic signed [obis_pkg::VALUE_BITS-1:0] rsp_value_milli,
   output logic [2:0]                     rsp_line_status
);
   import obis_pkg::*;

   logic                            valid_ff, valid_in;
   logic [IDX_BITS-1:0]             index_ff, index_in;
   logic [VALUE_BITS-1:0]           value_ff, value_in;
   status_type                      status_ff, status_in;
   logic [VALUE_BITS+SCALE_BITS-1:0] scaled [FRAC_DIGITS+1];
   logic [VALUE_BITS+SCALE_BITS-1:0] product;
   logic [VALUE_BITS-1:0]           mag;
   logic                            emit;

   assign emit    = line_end && code_info.dash_seen && !code_info.stamp_seen;

   // one constant multiply per possible fraction count, then pick
   always_comb begin
      for (int j = 0; j <= FRAC_DIGITS; j++) begin
         scaled[j] = {{SCALE_BITS{1'b0}}, num_info.acc} *
                     {{VALUE_BITS{1'b0}}, frac_scale(FC_BITS'(j))};
      end
   end

   assign product = scaled[num_info.frac_cnt];
   assign mag     = (product > {{SCALE_BITS{1'b0}}, MAG_CAP}) ? MAG_CAP
                                                              : product[VALUE_BITS-1:0];

   always_comb begin
      index_in  = code_info.index;
      value_in  = '0;
      status_in = ST_OK;
      if (!code_info.matched) begin
         status_in = ST_UNKNOWN;
         index_in  = '0;
      end else if (num_info.phase == PH_CODE) begin
         status_in = ST_NO_PAREN;
      end else if (num_info.phase != PH_STAR) begin
         status_in = ST_NO_STAR;
      end else if (!num_info.digit) begin
         status_in = ST_NO_DIGITS;
      end else if (num_info.neg) begin
         value_in = -mag;
      end else begin
         value_in = (mag == MAG_CAP) ? MAG_CAP - VALUE_BITS'(1) : mag;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         index_ff  <= index_in;
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_quantity_index = index_ff;
   assign rsp_value_milli    = value_ff;
   assign rsp_line_status    = status_ff;

endmodule

// ----- hw/rtl/obis_meter_line_parser.sv -----
// obis meter line parser, top level
// depends on obis_pkg, obis_code_match, obis_num_parse, obis_result
//
// usage:
//   req channel: one telegram byte per beat (req_data_byte). carriage return is
//   dropped, line feed closes the line.
//   rsp channel: at most one beat per line, on its line feed. lines with no dash
//   or holding the timestamp code give nothing. a beat carries the table
//   position of the matched code, the value in milli-units (saturated, two's
//   complement) and a status code.
// throughput: one byte per cycle while req_ready is high. each byte updates the
//   registered line state; code matching runs incrementally, one table column per byte.
// latency: the result beat shows on rsp_valid the cycle after its line feed
//   beat is taken, from a single result register.
// stall: while a result waits on rsp_ready, req_ready stays high as soon as
//   rsp_ready is high; with rsp_ready low it drops until the result leaves.
// reset: synchronous, clears line state and drops any pending result; the
//   block takes bytes in the first cycle after reset.
module obis_meter_line_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [obis_pkg::IDX_BITS-1:0]          rsp_quantity_index,
   output logic signed [obis_pkg::VALUE_BITS-1:0] rsp_value_milli,
   output logic [2:0]                             rsp_line_status
);
   import obis_pkg::*;

   logic          accept;
   logic          step;
   logic          line_end;
   code_info_type code_info;
   num_info_type  num_info;

   assign req_ready = !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign line_end  = accept && (req_data_byte == CHAR_LF);
   assign step      = accept && (req_data_byte != CHAR_LF) && (req_data_byte != CHAR_CR);

   obis_code_match u_code (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .line_end  (line_end),
      .in_code   (num_info.phase == PH_CODE),
      .data_byte (req_data_byte),
      .code_info (code_info)
   );

   obis_num_parse u_num (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .line_end  (line_end),
      .data_byte (req_data_byte),
      .num_info  (num_info)
   );

   obis_result u_result (
      .clock              (clock),
      .reset              (reset),
      .line_end           (line_end),
      .code_info          (code_info),
      .num_info           (num_info),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_quantity_index (rsp_quantity_index),
      .rsp_value_milli    (rsp_value_milli),
      .rsp_line_status    (rsp_line_status)
   );

endmodule

// ----- hw/rtl/obis_checker.sv -----
// port-level checks for the obis meter line parser, bound to the top level
// depends on obis_pkg and obis_meter_line_parser_macros.svh
`include "obis_meter_line_parser_macros.svh"

module obis_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic [7:0]                             req_data_byte,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [obis_pkg::IDX_BITS-1:0]          rsp_quantity_index,
   input logic signed [obis_pkg::VALUE_BITS-1:0] rsp_value_milli,
   input logic [2:0]                             rsp_line_status
);
   import obis_pkg::*;

   // a new result only follows a line feed beat
   `OBIS_ASSERT_IMPLY(a_rsp_after_lf, $rose(rsp_valid),
      $past(req_valid && req_ready && req_data_byte == CHAR_LF),
      "result without a preceding line feed")

   // a stalled result holds
   `OBIS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_value_milli) && $stable(rsp_line_status)
      && $stable(rsp_quantity_index),
      "stalled result changed")

   // only an ok line carries a value
   `OBIS_ASSERT_IMPLY(a_value_zero, rsp_valid && rsp_line_status != ST_OK,
      rsp_value_milli == '0, "value set on a failed line")

   // an unknown code reports position zero
   `OBIS_ASSERT_IMPLY(a_unknown_index, rsp_valid && rsp_line_status == ST_UNKNOWN,
      rsp_quantity_index == '0, "index set on an unknown code")

endmodule

bind obis_meter_line_parser obis_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_data_byte      (req_data_byte),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_quantity_index (rsp_quantity_index),
   .rsp_value_milli    (rsp_value_milli),
   .rsp_line_status    (rsp_line_status)
);
